/* rtl/dsws_pkg.sv */
// shared types and constants for the divisor sum window sieve
// no dependencies; imported by divisor_sum_window_sieve_top and its testbench
`default_nettype none

package dsws_pkg;

    localparam int OFFSET_W = 12;
    localparam int SUM_W    = 36;

    localparam logic OP_SIEVE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOWIN  = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [31:0]      LIMIT_RESET = 32'd500000000;

    typedef struct packed {
        logic                operation;
        logic [31:0]         window_start;
        logic [OFFSET_W-1:0] entry_offset;
    } req_t;

    typedef struct packed {
        logic [SUM_W-1:0] divisor_sum;
        logic [31:0]      number_value;
        logic [1:0]       status;
    } rsp_t;

endpackage

`default_nettype wire

/* rtl/divisor_sum_window_sieve_top.sv */
// divisor sum window sieve: window store, sieve sequencer, divider and read path
// depends on dsws_pkg for the item structs, codes and constants
//
// usage
//   req channel (req_valid/req_stall/req_item): one transfer per item. A sieve
//   item fills the window store with sigma(g) for g in [start, end), where end
//   is min(start + WINDOW_ENTRIES, search limit); a read item returns one entry.
//   rsp channel (rsp_valid/rsp_stall/rsp_item): exactly one result per item,
//   in order; a sieve gives an all-zero acknowledgement.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the search limit; write
//   it only while no item is in flight. cfg_ready is always high.
// operation
//   read: the result passes through the store read, status and output regs;
//   the next item is taken only once that result has moved to the output reg.
//   sieve: clears the first count entries, count being the window size; each
//   divisor d up to sqrt(end-1) costs a 32-step restoring divider pass for its
//   first multiple, then one pipelined read-modify-write cycle per multiple of
//   d in the window.
//   one item is worked on at a time; req_stall is high while it is busy.
// reset
//   no window is sieved, search limit is 500000000, the store is not cleared.
// stall
//   a finished result waits in its own register while rsp_stall is high.
`default_nettype none

module divisor_sum_window_sieve_top #(
    parameter int WINDOW_ENTRIES = 4096
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  dsws_pkg::req_t      req_item,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output dsws_pkg::rsp_t      rsp_item,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [31:0]         cfg_data
);
    import dsws_pkg::*;

    localparam int AW = $clog2(WINDOW_ENTRIES);
    localparam int CW = $clog2(WINDOW_ENTRIES + 1);
    localparam int TW = 2 * CW;
    localparam logic [32:0] WIN33 = 33'(WINDOW_ENTRIES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDWAIT = 4'd1;
    localparam logic [3:0] S_SETUP  = 4'd2;
    localparam logic [3:0] S_COUNT  = 4'd3;
    localparam logic [3:0] S_CLEAR  = 4'd4;
    localparam logic [3:0] S_DSQ    = 4'd5;
    localparam logic [3:0] S_DCHK   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_MSET   = 4'd8;
    localparam logic [3:0] S_WALK   = 4'd9;
    localparam logic [3:0] S_FIX1   = 4'd10;
    localparam logic [3:0] S_FIX2   = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [31:0]         limit_reg, limit_next;
    logic [31:0]         start_reg, start_next;
    logic [32:0]         end_reg, end_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ready_reg, ready_next;
    logic [31:0]         last_reg, last_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic [16:0]         d_reg, d_next;
    logic [33:0]         sq_reg, sq_next;
    logic [31:0]         lo_reg, lo_next;
    logic [31:0]         div_reg, div_next;
    logic [16:0]         rem_reg, rem_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [32:0]         m_reg, m_next;
    logic [31:0]         q_reg, q_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [32:0]         pend_inc_reg, pend_inc_next;
    logic [TW-1:0]       tri_reg, tri_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [SUM_W-1:0]    sum_mem [WINDOW_ENTRIES];
    logic [SUM_W-1:0]    rd_data_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_wa, mem_ra;
    logic [SUM_W-1:0]    mem_wd;

    logic                req_go;
    logic [32:0]         win_sum;
    logic [32:0]         win_diff;
    logic [17:0]         rem_sh;
    logic                rem_nz;
    logic [32:0]         walk_diff;
    logic [36:0]         acc_sum;
    logic [63:0]         tri_half;
    logic [SUM_W-1:0]    fix_val;

    assign req_stall = (state_reg != S_IDLE);
    assign req_go    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign win_sum   = {1'b0, start_reg} + WIN33;
    assign win_diff  = end_reg - {1'b0, start_reg};
    assign rem_sh    = {rem_reg, div_reg[31]};
    assign rem_nz    = (rem_reg != 17'd0);
    assign walk_diff = m_reg - {1'b0, start_reg};
    assign acc_sum   = {1'b0, rd_data_reg} + 37'(pend_inc_reg);
    assign tri_half  = 64'(tri_reg >> 1);

    always_comb
    begin
        if (end_reg < 33'd2)
            fix_val = SUM_W'(1);
        else if (tri_half > 64'(SUM_MAX))
            fix_val = SUM_MAX;
        else
            fix_val = tri_half[SUM_W-1:0];
    end

    // store write and read port
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = '0;
        if (pend_vld_reg)
        begin
            mem_we = 1'b1;
            mem_wa = pend_idx_reg;
            mem_wd = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        end
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg[AW-1:0];
            mem_wd = '0;
        end
        if (state_reg == S_FIX2)
        begin
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = fix_val;
        end
        if (state_reg == S_IDLE && req_go && req_item.operation == OP_READ)
        begin
            mem_re = 1'b1;
            mem_ra = AW'(req_item.entry_offset);
        end
        if (state_reg == S_WALK && m_reg <= {1'b0, last_reg})
        begin
            mem_re = 1'b1;
            mem_ra = walk_diff[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            sum_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= sum_mem[mem_ra];
    end

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        last_next      = last_reg;
        off_next       = off_reg;
        clr_next       = clr_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        lo_next        = lo_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        q_next         = q_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pend_inc_next  = pend_inc_reg;
        tri_next       = tri_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (cfg_valid && cfg_ready)
            limit_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_go)
                begin
                    if (req_item.operation == OP_READ)
                    begin
                        off_next   = req_item.entry_offset;
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        start_next = req_item.window_start;
                        state_next = S_SETUP;
                    end
                end
            end
            S_RDWAIT:
            begin
                res_next = '0;
                if (!ready_reg)
                    res_next.status = ST_NOWIN;
                else
                begin
                    res_next.number_value = start_reg + 32'(off_reg);
                    if (33'(off_reg) >= 33'(count_reg))
                        res_next.status = ST_RANGE;
                    else
                    begin
                        res_next.status      = ST_OK;
                        res_next.divisor_sum = rd_data_reg;
                    end
                end
                state_next = S_EMIT;
            end
            S_SETUP:
            begin
                end_next   = (win_sum > {1'b0, limit_reg}) ? {1'b0, limit_reg} : win_sum;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                ready_next = 1'b1;
                last_next  = 32'(end_reg - 33'd1);
                clr_next   = '0;
                if (end_reg > {1'b0, start_reg})
                begin
                    count_next = win_diff[CW-1:0];
                    state_next = S_CLEAR;
                end
                else
                begin
                    count_next = '0;
                    res_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_CLEAR:
            begin
                if (clr_reg == count_reg - CW'(1))
                begin
                    d_next     = 17'd1;
                    state_next = S_DSQ;
                end
                else
                    clr_next = clr_reg + CW'(1);
            end
            S_DSQ:
            begin
                sq_next    = 34'(d_reg) * 34'(d_reg);
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (sq_reg > {2'b00, last_reg})
                begin
                    if (start_reg == 32'd0)
                        state_next = S_FIX1;
                    else
                    begin
                        res_next   = '0;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    lo_next    = (start_reg >= sq_reg[31:0]) ? start_reg : sq_reg[31:0];
                    div_next   = (start_reg >= sq_reg[31:0]) ? start_reg : sq_reg[31:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_sh >= {1'b0, d_reg})
                begin
                    rem_next = 17'(rem_sh - {1'b0, d_reg});
                    div_next = {div_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[16:0];
                    div_next = {div_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_MSET;
            end
            S_MSET:
            begin
                // round the first multiple up to a multiple of d
                q_next     = div_reg + 32'(rem_nz);
                m_next     = {1'b0, lo_reg} + (rem_nz ? 33'(d_reg - rem_reg) : 33'd0);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (m_reg <= {1'b0, last_reg})
                begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = walk_diff[AW-1:0];
                    // divisor plus its cofactor, once for a square
                    pend_inc_next = (q_reg != 32'(d_reg)) ? 33'(d_reg) + 33'(q_reg)
                                                          : 33'(d_reg);
                    m_next        = m_reg + 33'(d_reg);
                    q_next        = q_reg + 32'd1;
                end
                else
                begin
                    d_next     = d_reg + 17'd1;
                    state_next = S_DSQ;
                end
            end
            S_FIX1:
            begin
                tri_next   = TW'(end_reg[CW-1:0]) * TW'(end_reg[CW-1:0] - CW'(1));
                state_next = S_FIX2;
            end
            S_FIX2:
            begin
                res_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            start_reg     <= '0;
            end_reg       <= '0;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            pend_vld_reg  <= pend_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        off_reg      <= off_next;
        clr_reg      <= clr_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        lo_reg       <= lo_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        m_reg        <= m_next;
        q_reg        <= q_next;
        pend_idx_reg <= pend_idx_next;
        pend_inc_reg <= pend_inc_next;
        tri_reg      <= tri_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // a pending accumulate never meets the clear sweep or the zero entry fix
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg != S_CLEAR && state_reg != S_FIX2))
        else $error("accumulate write collides with another store write");

    // every multiple walked lies inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && m_reg <= {1'b0, last_reg})
            |-> (m_reg >= {1'b0, start_reg} && walk_diff < WIN33))
        else $error("walk index outside window");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MSET) |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    // an accepted item always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        req_go |=> (state_reg == S_RDWAIT || state_reg == S_SETUP))
        else $error("accepted item not started");

endmodule

`default_nettype wire

/* test/divisor_sum_window_sieve_top_test.sv */
// self-checking testbench for divisor_sum_window_sieve_top: a table of directed items,
// then random phases of sieves and reads under changing search limits
// depends on dsws_pkg and the rtl of divisor_sum_window_sieve_top
module divisor_sum_window_sieve_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsws_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int WINDOW_ENTRIES = 4096;
    localparam int QUIET_LIMIT    = 1000000;
    localparam int DRAIN_LIMIT    = 1000000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_ITEMS    = 16;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic typed;
        rsp_t want;
    } want_t;

    typedef struct packed {
        logic        is_cfg;
        logic [31:0] limit;
        req_t        item;
        want_t       want_row;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req_item;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // predicted state of the window
    logic [31:0]     pw_limit = LIMIT_RESET;
    logic [31:0]     pw_start = '0;
    logic [32:0]     pw_end   = '0;
    logic            pw_ready = 1'b0;
    logic [SUM_W-1:0] pw_sums [WINDOW_ENTRIES];
    longint unsigned sigma_acc [WINDOW_ENTRIES];

    rsp_t      sigma_due_q [$];
    want_t     table_want_q [$];
    stim_row_t dir_rows [$];

    int items_sent    = 0;
    int results_taken = 0;
    int fault_count   = 0;
    int sieves_done   = 0;
    int reads_done    = 0;
    int limit_writes  = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    bit hold_wanted   = 1'b0;
    bit hold_given    = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    divisor_sum_window_sieve_top #(
        .WINDOW_ENTRIES(WINDOW_ENTRIES)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_item (req_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item (rsp_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    function automatic void fill_sigma_window(input logic [31:0] first);
        longint unsigned lo_g;
        longint unsigned hi_g;
        longint unsigned cnt;
        longint unsigned top_g;
        longint unsigned d;
        longint unsigned m;
        longint unsigned q;
        longint unsigned i;
        lo_g = 64'(first);
        hi_g = lo_g + WINDOW_ENTRIES;
        if (64'(pw_limit) < hi_g)
            hi_g = 64'(pw_limit);
        cnt = (hi_g > lo_g) ? hi_g - lo_g : 0;
        for (i = 0; i < WINDOW_ENTRIES; i++)
            sigma_acc[i] = (i < cnt) ? 0 : 1;
        if (cnt > 0)
        begin
            top_g = hi_g - 1;
            // each divisor up to the square root also brings its cofactor
            for (d = 1; d * d <= top_g; d++)
            begin
                m = (lo_g > d * d) ? lo_g : d * d;
                m = ((m + d - 1) / d) * d;
                while (m <= top_g)
                begin
                    q = m / d;
                    sigma_acc[m - lo_g] += d;
                    if (q != d)
                        sigma_acc[m - lo_g] += q;
                    m += d;
                end
            end
            // zero is a multiple of every divisor tried
            if (lo_g == 0)
                sigma_acc[0] = (hi_g >= 2) ? (hi_g * (hi_g - 1)) / 2 : 1;
        end
        for (i = 0; i < WINDOW_ENTRIES; i++)
            pw_sums[i] = (sigma_acc[i] > 64'(SUM_MAX)) ? SUM_MAX : sigma_acc[i][SUM_W-1:0];
        pw_start = first;
        pw_end   = hi_g[32:0];
        pw_ready = 1'b1;
    endfunction

    function automatic rsp_t predict_result(input req_t item);
        rsp_t            r;
        longint unsigned span;
        r = '0;
        if (item.operation == OP_SIEVE)
            fill_sigma_window(item.window_start);
        else if (!pw_ready)
            r.status = ST_NOWIN;
        else
        begin
            r.number_value = pw_start + 32'(item.entry_offset);
            span = (pw_end > {1'b0, pw_start}) ? 64'(pw_end - {1'b0, pw_start}) : 64'd0;
            if (64'(item.entry_offset) >= span)
                r.status = ST_RANGE;
            else
                r.divisor_sum = pw_sums[item.entry_offset];
        end
        return r;
    endfunction

    function automatic void table_cfg(input logic [31:0] value);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.limit  = value;
        dir_rows.push_back(row);
    endfunction

    function automatic void table_item(input logic op, input logic [31:0] start,
                                       input logic [OFFSET_W-1:0] offset);
        stim_row_t row;
        row = '0;
        row.item.operation    = op;
        row.item.window_start = start;
        row.item.entry_offset = offset;
        dir_rows.push_back(row);
    endfunction

    function automatic void table_check(input logic op, input logic [31:0] start,
                                        input logic [OFFSET_W-1:0] offset,
                                        input logic [SUM_W-1:0] sum,
                                        input logic [31:0] number, input logic [1:0] st);
        stim_row_t row;
        row = '0;
        row.item.operation    = op;
        row.item.window_start = start;
        row.item.entry_offset = offset;
        row.want_row.typed              = 1'b1;
        row.want_row.want.divisor_sum   = sum;
        row.want_row.want.number_value  = number;
        row.want_row.want.status        = st;
        dir_rows.push_back(row);
    endfunction

    task automatic push_item(input req_t item, input want_t want_row);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        table_want_q.push_back(want_row);
        req_item  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_limit(input logic [31:0] value);
        req_valid <= 1'b0;
        while (results_taken != items_sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    // prediction at each input transfer, comparison at each result transfer
    always @(posedge clk)
    begin
        rsp_t  want;
        want_t row_want;
        if (cfg_valid && cfg_ready)
            pw_limit = cfg_data;
        if (req_valid && !req_stall)
        begin
            want = predict_result(req_item);
            row_want = table_want_q.pop_front();
            if (row_want.typed)
                want = row_want.want;
            sigma_due_q.push_back(want);
            if (req_item.operation == OP_SIEVE)
                sieves_done++;
            else
                reads_done++;
        end
        if (rsp_valid && !rsp_stall)
        begin
            results_taken++;
            if (sigma_due_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: sum %h number %h status %0d",
                             $realtime, rsp_item.divisor_sum, rsp_item.number_value,
                             rsp_item.status);
            end
            else
            begin
                want = sigma_due_q.pop_front();
                if (rsp_item.divisor_sum !== want.divisor_sum ||
                    rsp_item.number_value !== want.number_value ||
                    rsp_item.status !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("%0t: mismatch sum %h/%h number %h/%h status %0d/%0d (exp/got)",
                                 $realtime, want.divisor_sum, rsp_item.divisor_sum,
                                 want.number_value, rsp_item.number_value,
                                 want.status, rsp_item.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: changing stall patterns, and one long hold-off
    initial
    begin
        int mode;
        int ticks;
        mode  = 0;
        ticks = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_given)
            begin
                hold_given = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (ticks == 0)
            begin
                mode  = $urandom_range(3, 0);
                ticks = $urandom_range(96, 16);
            end
            ticks--;
            case (mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= 1'($urandom_range(1, 0));
                2: rsp_stall <= ($urandom_range(4, 0) != 0);
                default: rsp_stall <= (ticks % 3 != 0);
            endcase
        end
    end

    initial
    begin
        req_t            item;
        want_t           no_want;
        int unsigned     gen_limit;
        int unsigned     gen_start;
        int unsigned     span;
        int unsigned     pick;
        longint unsigned gen_end;
        longint unsigned gen_count;
        int              waited;
        int              phase;
        int              n;
        int              r;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_item  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        no_want   = '0;
        gen_count = 0;

        // reads before any sieve, then the reset limit seen through an empty window
        table_check(OP_READ, 32'd0, 12'd0, 36'd0, 32'd0, ST_NOWIN);
        table_check(OP_READ, 32'hFFFF_FFFF, 12'hFFF, 36'd0, 32'd0, ST_NOWIN);
        table_check(OP_SIEVE, 32'd500000000, 12'hFFF, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd0, 32'd500000000, ST_RANGE);
        // smallest limit
        table_cfg(32'd2);
        table_check(OP_SIEVE, 32'd1, 12'd0, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd1, 32'd1, ST_OK);
        table_check(OP_READ, 32'd0, 12'd1, 36'd0, 32'd2, ST_RANGE);
        table_check(OP_SIEVE, 32'd0, 12'd0, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd1, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd1, 36'd1, 32'd1, ST_OK);
        // largest limit, full windows
        table_cfg(32'hFFFF_FFFF);
        table_check(OP_SIEVE, 32'd0, 12'hFFF, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd8386560, 32'd0, ST_OK);
        table_item(OP_READ, 32'd0, 12'hFFF);
        table_check(OP_SIEVE, 32'd10000000, 12'd0, 36'd0, 32'd0, ST_OK);
        table_item(OP_READ, 32'd0, 12'd0);
        table_item(OP_READ, 32'd0, 12'hFFF);
        table_item(OP_READ, 32'd0, 12'd2047);
        // windows past the limit, number wrapping, a clipped window
        table_cfg(32'd100);
        table_check(OP_SIEVE, 32'hFFFF_FFFE, 12'd0, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd0, 32'hFFFF_FFFE, ST_RANGE);
        table_check(OP_READ, 32'd0, 12'hFFF, 36'd0, 32'd4093, ST_RANGE);
        table_check(OP_SIEVE, 32'd100, 12'd0, 36'd0, 32'd0, ST_OK);
        table_check(OP_READ, 32'd0, 12'd0, 36'd0, 32'd100, ST_RANGE);
        table_check(OP_SIEVE, 32'd97, 12'd0, 36'd0, 32'd0, ST_OK);
        table_item(OP_READ, 32'd0, 12'd2);
        table_check(OP_READ, 32'd0, 12'd3, 36'd0, 32'd100, ST_RANGE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < dir_rows.size(); r++)
        begin
            if (dir_rows[r].is_cfg)
                write_limit(dir_rows[r].limit);
            else
                push_item(dir_rows[r].item, dir_rows[r].want_row);
        end

        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            case ($urandom_range(5, 0))
                0: gen_limit = $urandom_range(32, 2);
                1: gen_limit = $urandom_range(200000, 4096);
                default: gen_limit = $urandom_range(20000, 2);
            endcase
            write_limit(gen_limit);
            if (phase == 1)
                hold_wanted = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                item.window_start = $urandom;
                item.entry_offset = OFFSET_W'($urandom_range(4095, 0));
                if ($urandom_range(4, 0) == 0 || (n == 0 && $urandom_range(1, 0) == 1))
                begin
                    pick = $urandom_range(9, 0);
                    if (pick < 2)
                        gen_start = $urandom;
                    else if (pick == 2)
                        gen_start = 0;
                    else
                    begin
                        // mostly short windows clipped by the limit
                        span = ($urandom_range(7, 0) == 0) ? WINDOW_ENTRIES : $urandom_range(256, 1);
                        if (gen_limit > span)
                            gen_start = gen_limit - $urandom_range(span, 1);
                        else
                            gen_start = $urandom_range(gen_limit - 1, 0);
                    end
                    gen_end = 64'(gen_start);
                    gen_end += WINDOW_ENTRIES;
                    if (64'(gen_limit) < gen_end)
                        gen_end = 64'(gen_limit);
                    gen_count = (gen_end > 64'(gen_start)) ? gen_end - 64'(gen_start) : 0;
                    item.operation    = OP_SIEVE;
                    item.window_start = gen_start;
                end
                else
                begin
                    item.operation = OP_READ;
                    if (gen_count > 0 && $urandom_range(9, 0) < 6)
                        item.entry_offset =
                            OFFSET_W'($urandom_range(32'(gen_count - 1), 0));
                end
                push_item(item, no_want);
            end
        end

        req_valid <= 1'b0;
        waited = 0;
        while (results_taken != items_sent && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);

        if (sigma_due_q.size() != 0)
            $display("%0d expected results never arrived", sigma_due_q.size());
        $display("run covered %0d window sieves and %0d entry reads over %0d limit settings",
                 sieves_done, reads_done, limit_writes + 1);
        $display("%0d results compared, %0d failures", results_taken, fault_count);
        if (fault_count == 0 && sigma_due_q.size() == 0 && results_taken == items_sent)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsws_pkg.sv
rtl/divisor_sum_window_sieve_top.sv
test/divisor_sum_window_sieve_top_test.sv
